// ===== rtl/core/swmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants for the sliding-window mean and median filter.
// ---------------------------------------------------------------------------
package swmm_pkg;

    // register file layout
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_ADDR_LSB = 2;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    // field widths fixed by the register map and result format
    localparam int LEN_REG_W = 5;
    localparam int COUNT_W   = 5;
    localparam logic [LEN_REG_W-1:0] WINDOW_LENGTH_RESET = 5'd16;

    // top-level sequencer
    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_FETCH,
        TOP_RUN,
        TOP_WAIT,
        TOP_OUT
    } top_state_t;

    // sorted-list maintenance sequencer
    typedef enum logic [2:0] {
        SRT_IDLE,
        SRT_REM,
        SRT_INS,
        SRT_TAIL,
        SRT_MED_RD,
        SRT_MED_CAP,
        SRT_DONE
    } sort_state_t;

    // serial divider
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // command from the sequencer to the sorted-list unit
    typedef struct packed {
        logic start;
        logic remove;
    } sort_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/swmm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmm_if
// Valid/ready channels for samples in and filter results out.
// ---------------------------------------------------------------------------
interface swmm_in_if #(parameter int SAMPLE_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swmm_out_if #(parameter int SAMPLE_BITS = 32);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0] median_value;
    logic                   window_full;
    logic [4:0]             valid_count;

    modport source (output valid, output mean_value, output median_value,
                    output window_full, output valid_count, input ready);
    modport sink   (input valid, input mean_value, input median_value,
                    input window_full, input valid_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/swmm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmm_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module swmm_div #(
    parameter int DIVIDEND_W = 37,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    import swmm_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    div_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]  quot_reg, quot_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0]   dvsr_reg, dvsr_next;
    logic [DIVISOR_W:0]     rem_shift;
    logic [DIVISOR_W:0]     rem_diff;
    logic                   rem_ge;

    // one restoring step
    assign rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvsr_reg});
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        unique case (state_reg)
            DIV_IDLE, DIV_DONE:
            begin
                if (start)
                begin
                    quot_next  = dividend;
                    rem_next   = '0;
                    dvsr_next  = divisor;
                    cnt_next   = CNT_W'(DIVIDEND_W);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                quot_next = {quot_reg[DIVIDEND_W-2:0], rem_ge};
                rem_next  = rem_ge ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = DIV_DONE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = (state_reg == DIV_DONE);
    assign quotient = quot_reg;

endmodule
`default_nettype wire

// ===== rtl/core/swmm_sort.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swmm_sort
// Keeps the valid samples in ascending order in a small memory. Per sample:
// an optional pass that drops the overwritten value, an insertion pass for
// the new value, then one read of the middle entry.
// ---------------------------------------------------------------------------
module swmm_sort #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  swmm_pkg::sort_cmd_t                   cmd,
    input  logic [SAMPLE_BITS-1:0]                old_value,
    input  logic [SAMPLE_BITS-1:0]                new_value,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]       count_before,
    output logic                                  done,
    output logic [SAMPLE_BITS-1:0]                median
);
    import swmm_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);

    sort_state_t            state_reg, state_next;
    logic [LEN_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic [LEN_W-1:0]       pr_cnt_reg, pr_cnt_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   pend_reg, pend_next;
    logic                   found_reg, found_next;
    logic [SAMPLE_BITS-1:0] hold_reg, hold_next;
    logic [SAMPLE_BITS-1:0] median_reg, median_next;

    logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]       raddr;
    logic [IDX_W-1:0]       waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic                   we;

    logic [LEN_W-1:0]       pr_prev;
    logic [LEN_W-1:0]       med_idx;
    logic                   in_pass;
    logic                   pass_end;

    assign pr_prev  = pr_cnt_reg - 1'b1;
    assign med_idx  = len_reg >> 1;
    assign in_pass  = (state_reg == SRT_REM) || (state_reg == SRT_INS);
    assign pass_end = !pend_reg && (rd_cnt_reg == len_reg);

    // sorted-list memory, read-first
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        pr_cnt_next = pr_cnt_reg;
        len_next    = len_reg;
        pend_next   = pend_reg;
        found_next  = found_reg;
        hold_next   = hold_reg;
        median_next = median_reg;
        raddr       = '0;
        waddr       = '0;
        wdata       = hold_reg;
        we          = 1'b0;

        // read stream shared by both passes
        if (in_pass)
        begin
            if (rd_cnt_reg != len_reg)
            begin
                raddr       = rd_cnt_reg[IDX_W-1:0];
                rd_cnt_next = rd_cnt_reg + 1'b1;
                pend_next   = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (pend_reg)
            begin
                pr_cnt_next = pr_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            SRT_IDLE, SRT_DONE:
            begin
                if (cmd.start)
                begin
                    hold_next   = new_value;
                    len_next    = count_before;
                    rd_cnt_next = '0;
                    pr_cnt_next = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    state_next  = cmd.remove ? SRT_REM : SRT_INS;
                end
            end
            // drop the first copy of the old value, close the gap
            SRT_REM:
            begin
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        we    = 1'b1;
                        waddr = pr_prev[IDX_W-1:0];
                        wdata = rdata_reg;
                    end
                    else if (rdata_reg == old_value)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (pass_end)
                begin
                    len_next    = len_reg - 1'b1;
                    rd_cnt_next = '0;
                    pr_cnt_next = '0;
                    pend_next   = 1'b0;
                    state_next  = SRT_INS;
                end
            end
            // carry the new value upward, swapping past larger entries
            SRT_INS:
            begin
                if (pend_reg && (rdata_reg > hold_reg))
                begin
                    we        = 1'b1;
                    waddr     = pr_cnt_reg[IDX_W-1:0];
                    wdata     = hold_reg;
                    hold_next = rdata_reg;
                end
                if (pass_end)
                begin
                    state_next = SRT_TAIL;
                end
            end
            SRT_TAIL:
            begin
                we         = 1'b1;
                waddr      = len_reg[IDX_W-1:0];
                wdata      = hold_reg;
                len_next   = len_reg + 1'b1;
                state_next = SRT_MED_RD;
            end
            SRT_MED_RD:
            begin
                raddr      = med_idx[IDX_W-1:0];
                state_next = SRT_MED_CAP;
            end
            SRT_MED_CAP:
            begin
                median_next = rdata_reg;
                state_next  = SRT_DONE;
            end
            default:
            begin
                state_next = SRT_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SRT_IDLE;
            rd_cnt_reg <= '0;
            pr_cnt_reg <= '0;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            pr_cnt_reg <= pr_cnt_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
            found_reg  <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        median_reg <= median_next;
    end

    assign done   = (state_reg == SRT_DONE);
    assign median = median_reg;

endmodule
`default_nettype wire

// ===== rtl/core/sliding_window_mean_median.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sliding_window_mean_median
// Moving average and moving median over a circular window of samples.
// ---------------------------------------------------------------------------
// Usage:
//   samples : one unsigned sample per beat (valid/ready).
//   results : one beat per sample with the truncated mean, the upper median,
//             the window-full flag and the number of valid samples.
//   APB     : register 0 (byte address 0) is window_length; a write restarts
//             the window (count, write slot and running sum cleared).
// Sequence: a sample takes a fetch state and a start state, then waits for
// both the serial divider (one quotient bit per cycle) and the sorted-list
// update (one memory read per cycle; longer once the window is full, shorter
// while it fills), then an output state, and the filter returns to idle.
// One sample is in flight at a time; ready is high only while idle.
// Reset: window_length returns to 16, the window is empty, no result pending.
// A stalled receiver holds the finished result in the output register; the
// next sample can still be taken and processed, and waits for that slot.
// ---------------------------------------------------------------------------
module sliding_window_mean_median #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swmm_pkg::PADDR_W-1:0]   paddr,
    input  logic [swmm_pkg::PDATA_W-1:0]   pwdata,
    output logic [swmm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    swmm_in_if.sink                        samples,
    swmm_out_if.source                     results
);
    import swmm_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_BITS + LEN_W;

    top_state_t             state_reg, state_next;
    logic [LEN_REG_W-1:0]   wl_reg, wl_next;
    logic [IDX_W-1:0]       wp_reg, wp_next;
    logic [LEN_W-1:0]       fc_reg, fc_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [SAMPLE_BITS-1:0] old_reg, old_next;
    logic                   full_before_reg, full_before_next;
    logic [LEN_W-1:0]       n_before_reg, n_before_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [SAMPLE_BITS-1:0] median_reg;
    logic                   full_out_reg;
    logic [COUNT_W-1:0]     count_out_reg;

    logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] store_rdata_reg;
    logic                   store_we;

    logic [LEN_W-1:0]       len;
    logic [IDX_W-1:0]       wp_eff;
    logic [LEN_W-1:0]       wp_plus;
    logic                   full_now;
    logic                   cfg_we;
    logic [0:0]             reg_idx;
    logic                   in_beat;
    logic                   out_beat;
    logic                   out_load;

    sort_cmd_t              sort_cmd;
    logic                   sort_done;
    logic [SAMPLE_BITS-1:0] sort_median;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;

    // register port
    assign reg_idx = paddr[PADDR_W-1:REG_ADDR_LSB];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_WINDOW_LENGTH) ? PDATA_W'(wl_reg) : '0;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (wl_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(wl_reg) > MAX_WINDOW)
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = LEN_W'(wl_reg);
        end
    end

    // write slot and fill status
    assign wp_eff   = (LEN_W'(wp_reg) >= len) ? '0 : wp_reg;
    assign wp_plus  = LEN_W'(wp_eff) + 1'b1;
    assign full_now = (fc_reg >= len);

    // handshakes
    assign in_beat       = samples.valid && samples.ready;
    assign out_beat      = results.valid && results.ready;
    assign samples.ready = (state_reg == TOP_IDLE);
    assign out_load      = (state_reg == TOP_OUT) && (!out_valid_reg || results.ready);

    // sample window memory
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[wp_eff] <= sample_reg;
        end
        store_rdata_reg <= store_mem[wp_eff];
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        wl_next          = wl_reg;
        wp_next          = wp_reg;
        fc_next          = fc_reg;
        sum_next         = sum_reg;
        sample_next      = sample_reg;
        old_next         = old_reg;
        full_before_next = full_before_reg;
        n_before_next    = n_before_reg;
        store_we         = 1'b0;
        sort_cmd.start   = 1'b0;
        sort_cmd.remove  = full_before_reg;
        div_start        = 1'b0;

        unique case (state_reg)
            TOP_IDLE:
            begin
                if (in_beat)
                begin
                    sample_next = samples.sample;
                    state_next  = TOP_FETCH;
                end
            end
            // old slot value is out of memory: write the new one, update sum
            TOP_FETCH:
            begin
                store_we         = 1'b1;
                old_next         = store_rdata_reg;
                full_before_next = full_now;
                n_before_next    = fc_reg;
                fc_next          = full_now ? len : (fc_reg + 1'b1);
                wp_next          = (wp_plus >= len) ? '0 : wp_plus[IDX_W-1:0];
                sum_next         = sum_reg + SUM_W'(sample_reg)
                                   - (full_now ? SUM_W'(store_rdata_reg) : '0);
                state_next       = TOP_RUN;
            end
            TOP_RUN:
            begin
                sort_cmd.start = 1'b1;
                div_start      = 1'b1;
                state_next     = TOP_WAIT;
            end
            TOP_WAIT:
            begin
                if (sort_done && div_done)
                begin
                    state_next = TOP_OUT;
                end
            end
            TOP_OUT:
            begin
                if (out_load)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase

        // a length write restarts the window
        if (cfg_we && (reg_idx == REG_WINDOW_LENGTH))
        begin
            wl_next  = pwdata[LEN_REG_W-1:0];
            wp_next  = '0;
            fc_next  = '0;
            sum_next = '0;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_beat)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= TOP_IDLE;
            wl_reg          <= WINDOW_LENGTH_RESET;
            wp_reg          <= '0;
            fc_reg          <= '0;
            sum_reg         <= '0;
            full_before_reg <= 1'b0;
            n_before_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wl_reg          <= wl_next;
            wp_reg          <= wp_next;
            fc_reg          <= fc_next;
            sum_reg         <= sum_next;
            full_before_reg <= full_before_next;
            n_before_reg    <= n_before_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        old_reg    <= old_next;
        if (out_load)
        begin
            mean_reg      <= quotient[SAMPLE_BITS-1:0];
            median_reg    <= sort_median;
            full_out_reg  <= (fc_reg == len);
            count_out_reg <= COUNT_W'(fc_reg);
        end
    end

    // mean: running sum over valid count
    swmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fc_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // median: sorted copy of the window
    swmm_sort #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sort (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (sort_cmd),
        .old_value    (old_reg),
        .new_value    (sample_reg),
        .count_before (n_before_reg),
        .done         (sort_done),
        .median       (sort_median)
    );

    // result channel
    assign results.valid        = out_valid_reg;
    assign results.mean_value   = mean_reg;
    assign results.median_value = median_reg;
    assign results.window_full  = full_out_reg;
    assign results.valid_count  = count_out_reg;

    // checks
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= len)
        else $error("valid count exceeds window length");

    a_load_after_units: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (sort_done && div_done))
        else $error("result loaded before divider and sort finished");

    a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (quotient[SUM_W-1:SAMPLE_BITS] == '0))
        else $error("mean wider than a sample");

    a_restart_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (reg_idx == REG_WINDOW_LENGTH)) |=> (fc_reg == '0))
        else $error("window not restarted after length write");

endmodule
`default_nettype wire

// ===== test/swmm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swmm_checker
// Watches the register port and both beat channels of the filter. Keeps its
// own copy of the window and the length register, predicts mean, median,
// full flag and count for every sample taken, and compares each result beat
// in order against the oldest prediction.
// ---------------------------------------------------------------------------
module swmm_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swmm_pkg::PADDR_W-1:0] paddr,
    input  logic [swmm_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    swmm_in_if                           samples,
    swmm_out_if                          results,
    output int                           pending,
    output int                           fail_count
);
    import swmm_pkg::*;

    localparam int WIN_MAX = 16;
    localparam int SMP_W   = 32;

    typedef struct packed {
        logic [SMP_W-1:0]   mean;
        logic [SMP_W-1:0]   median;
        logic               full;
        logic [COUNT_W-1:0] count;
    } filter_result_t;

    // shadow of the window and the length register
    logic [SMP_W-1:0]     window_mem [WIN_MAX];
    logic [LEN_REG_W-1:0] length_reg;
    logic [4:0]           next_slot;
    logic [COUNT_W-1:0]   fill_cnt;
    filter_result_t       expected_q [$];
    filter_result_t       want;

    // register value 0 behaves as 1, anything above the window size as the size
    function automatic logic [4:0] active_length();
        logic [4:0] len;
        len = length_reg;
        if (len == 5'd0)
            len = 5'd1;
        if (len > 5'(WIN_MAX))
            len = 5'(WIN_MAX);
        return len;
    endfunction

    // store one sample and work out the filter outputs for the window
    function automatic filter_result_t take_sample(input logic [SMP_W-1:0] s);
        logic [4:0]       len;
        logic [SMP_W+4:0] sum;
        logic [SMP_W-1:0] sorted [WIN_MAX];
        logic [SMP_W-1:0] v;
        int               i;
        int               j;
        filter_result_t   r;
        len = active_length();
        if (next_slot >= len)
            next_slot = '0;
        window_mem[next_slot[3:0]] = s;
        next_slot = next_slot + 5'd1;
        if (next_slot >= len)
            next_slot = '0;
        if (fill_cnt < len)
            fill_cnt = fill_cnt + 5'd1;

        sum = '0;
        for (i = 0; i < fill_cnt; i++)
            sum = sum + window_mem[i];

        // insertion sort of the valid entries
        for (i = 0; i < fill_cnt; i++)
        begin
            v = window_mem[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end

        r.mean   = SMP_W'(sum / fill_cnt);
        r.median = sorted[fill_cnt[4:1]];
        r.full   = (fill_cnt == len);
        r.count  = fill_cnt;
        return r;
    endfunction

    // track register writes, compare result beats, queue predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg = WINDOW_LENGTH_RESET;
            next_slot  = '0;
            fill_cnt   = '0;
            fail_count = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[PADDR_W-1:REG_ADDR_LSB] == REG_WINDOW_LENGTH)
            begin
                length_reg = pwdata[LEN_REG_W-1:0];
                next_slot  = '0;
                fill_cnt   = '0;
            end

            if (results.valid && results.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no sample pending: mean_value %0h",
                           results.mean_value);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (results.mean_value !== want.mean)
                    begin
                        $error("mean_value: expected %0h, got %0h",
                               want.mean, results.mean_value);
                        fail_count++;
                    end
                    if (results.median_value !== want.median)
                    begin
                        $error("median_value: expected %0h, got %0h",
                               want.median, results.median_value);
                        fail_count++;
                    end
                    if (results.window_full !== want.full)
                    begin
                        $error("window_full: expected %0b, got %0b",
                               want.full, results.window_full);
                        fail_count++;
                    end
                    if (results.valid_count !== want.count)
                    begin
                        $error("valid_count: expected %0d, got %0d",
                               want.count, results.valid_count);
                        fail_count++;
                    end
                end
            end

            if (samples.valid && samples.ready)
                expected_q.push_back(take_sample(samples.sample));

            pending <= expected_q.size();
        end
    end

endmodule

// ===== test/sliding_window_mean_median_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_mean_median_tb
// Drives samples and window-length writes into the filter: a directed run
// over extreme values, wrap-around and the odd register values, then random
// phases with a fresh window length each, mixed sample flavors and random
// gaps and stalls on both channels. A checker beside the filter predicts
// and compares every result beat.
// ---------------------------------------------------------------------------
module sliding_window_mean_median_tb;
    import swmm_pkg::*;

    localparam int RANDOM_ITEMS = 1030;
    localparam int MAX_IDLE     = 13;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [PADDR_W-1:0] LENGTH_ADDR =
        PADDR_W'(REG_WINDOW_LENGTH) << REG_ADDR_LSB;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(1) << REG_ADDR_LSB;

    typedef enum int {
        IDLE_BOTH,
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER
    } idle_mode_t;

    typedef enum int {
        FLAVOR_ANY,
        FLAVOR_SMALL,
        FLAVOR_EXTREME,
        FLAVOR_HIGH
    } sample_flavor_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int pending;
    int fail_count;
    int stall_left;
    int stall_draw;
    bit sender_idles;
    bit receiver_stalls;

    swmm_in_if  #(.SAMPLE_BITS(32)) sample_ch ();
    swmm_out_if #(.SAMPLE_BITS(32)) result_ch ();

    sliding_window_mean_median #(
        .MAX_WINDOW  (16),
        .SAMPLE_BITS (32)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (sample_ch),
        .results (result_ch)
    );

    swmm_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .samples    (sample_ch),
        .results    (result_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result receiver: random stall after each beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (result_ch.valid && result_ch.ready)
        begin
            stall_draw = receiver_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            stall_left      <= stall_draw;
            result_ch.ready <= (stall_draw == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= (stall_left == 1);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    function automatic void set_idle_mode(input idle_mode_t mode);
        sender_idles    = (mode == IDLE_BOTH) || (mode == IDLE_SENDER);
        receiver_stalls = (mode == IDLE_BOTH) || (mode == IDLE_RECEIVER);
    endfunction

    function automatic logic [31:0] pick_sample(input sample_flavor_t flavor);
        logic [31:0] v;
        case (flavor)
            FLAVOR_SMALL:   v = $urandom_range(0, 7);
            FLAVOR_EXTREME:
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            FLAVOR_HIGH:    v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default:        v = $urandom;
        endcase
        return v;
    endfunction

    // one sample beat, preceded by a random gap
    task automatic send_sample(input logic [31:0] value);
        int gap;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // stop sending and wait for every predicted result to arrive
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // register write once the filter is idle; upper data bits are noise
    task automatic write_length(input logic [PADDR_W-1:0] addr,
                                input logic [LEN_REG_W-1:0] len);
        logic [PDATA_W-1:0] data;
        data = $urandom;
        data[LEN_REG_W-1:0] = len;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int             sent;
        int             phase;
        int             phase_items;
        logic [4:0]     len;
        sample_flavor_t flavor;

        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        set_idle_mode(IDLE_BOTH);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length: fill with a zero then all-ones, then wrap
        send_sample(32'h0000_0000);
        repeat (15) send_sample(32'hFFFF_FFFF);
        send_sample(32'h5555_5555);
        send_sample(32'hAAAA_AAAA);

        // length zero behaves as one
        write_length(LENGTH_ADDR, 5'd0);
        send_sample(32'h1234_5678);
        send_sample(32'h0000_0009);

        // write outside the register map leaves the window alone
        write_length(SPARE_ADDR, 5'd5);
        send_sample(32'h0000_0004);

        // even count picks the upper median
        write_length(LENGTH_ADDR, 5'd2);
        send_sample(32'h0000_0005);
        send_sample(32'h0000_0003);

        // random phases, each with a fresh window length
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       len = 5'd1;
                1:       len = 5'd16;
                2:       len = 5'd0;
                3:       len = 5'd31;
                4:       len = 5'd17;
                5:       len = 5'd8;
                default: len = 5'($urandom_range(0, 31));
            endcase
            write_length(LENGTH_ADDR, len);
            set_idle_mode(idle_mode_t'($urandom_range(0, 3)));
            flavor      = sample_flavor_t'($urandom_range(0, 3));
            phase_items = $urandom_range(10, 60);
            for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                if ($urandom_range(0, 9) < 6)
                    send_sample(pick_sample(flavor));
                else
                    send_sample(pick_sample(sample_flavor_t'($urandom_range(0, 3))));
                sent++;
            end
            phase++;
        end

        // wind down
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/swmm_pkg.sv
rtl/core/swmm_if.sv
rtl/core/swmm_div.sv
rtl/core/swmm_sort.sv
rtl/core/sliding_window_mean_median.sv
test/swmm_checker.sv
test/sliding_window_mean_median_tb.sv
